// File: rtl/core/rlm_pkg.sv
// rlm_pkg: shared constants, codes and sequencer states for the rsa letter cipher
// no dependencies; imported by every module of the block
package rlm_pkg;

    localparam int MW       = 32;              // modulus datapath width
    localparam int EW       = 17;              // width of the public exponent
    localparam int NW       = MW + EW;         // width of 1 + k*phi
    localparam int INV_BITS = 16;              // width of the fermat exponent e-2
    localparam logic [EW-1:0]       PUB_EXP  = 17'd65537;
    localparam logic [INV_BITS-1:0] INV_EXP  = 16'd65535;
    localparam logic [7:0]          CHAR_A   = 8'd65;
    localparam logic [7:0]          CHAR_Z   = 8'd90;

    localparam logic [2:0] ADDR_P = 3'd0;
    localparam logic [2:0] ADDR_Q = 3'd4;
    localparam logic [15:0] RST_P = 16'd257;
    localparam logic [15:0] RST_Q = 16'd263;

    localparam logic CMD_ENC = 1'b0;
    localparam logic CMD_DEC = 1'b1;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NO_INV  = 2'd1,
        ST_BAD_CHR = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RED_PHI,
        S_CHECK,
        S_SQ,
        S_MUL,
        S_PROD,
        S_DIV,
        S_RED_BASE,
        S_FIN
    } t_state;

endpackage

// File: rtl/core/rlm_if.sv
// rlm_in_if / rlm_out_if: valid-ready request and result channels of the cipher
// no dependencies; the widths are fixed in the interfaces
interface rlm_in_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [7:0]  plain_char;
    logic [31:0] cipher_value;
    modport source (output valid, command, plain_char, cipher_value, input ready);
    modport sink   (input valid, command, plain_char, cipher_value, output ready);
endinterface

interface rlm_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] result_value;
    logic [7:0]  result_char;
    logic [1:0]  status;
    modport source (output valid, result_value, result_char, status, input ready);
    modport sink   (input valid, result_value, result_char, status, output ready);
endinterface

// File: rtl/core/rsa_letter_modexp_cipher.sv
// rsa_letter_modexp_cipher: textbook rsa letter cipher with e = 65537, one item at a time
// sequence: encrypt reduces the letter and raises it to e, 20 modular products in all;
// decrypt runs 32 products for the fermat inverse, a divide, two reductions and up to 64
// products for c^d; the products and the divide are bit-serial
// a stalled result holds the next request
// reset: synchronous active low, primes return to 257 and 263, no result pending
module rsa_letter_modexp_cipher
    import rlm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    rlm_in_if.sink      i_in,
    rlm_out_if.source   o_out
);
    localparam int CW = $clog2(MW + 1);

    t_state        r_state, n_state;
    logic [15:0]   r_p, r_q;
    logic [MW-1:0] r_n, r_phi;
    logic          r_cmd;
    logic [7:0]    r_char;
    logic [31:0]   r_cv;
    logic [MW-1:0] r_acc, r_base, r_exp, r_mod, r_d;
    logic [CW-1:0] r_bits;
    logic          r_inv_phase;
    logic [NW-1:0] r_num;
    t_status       r_status;
    logic          r_issued;
    logic          r_ovalid;
    logic [31:0]   r_oval;
    logic [7:0]    r_ochar;
    t_status       r_ostat;

    logic          accept, out_free, chr_ok, last_bit, n_small;
    logic          mm_start, mm_done, dv_start, dv_done;
    logic [MW-1:0] mm_a, mm_b, mm_m, mm_res, dv_quo;
    logic [15:0]   p_m1, q_m1;
    logic [31:0]   n_prod, phi_prod;
    logic [EW-1:0] k_val;
    logic [7:0]    idx;

    // configuration
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_Q) ? {16'd0, r_q} : ((paddr == ADDR_P) ? {16'd0, r_p} : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p <= RST_P;
            r_q <= RST_Q;
        end else if (psel && penable && pwrite) begin
            if (paddr == ADDR_P) begin
                r_p <= pwdata[15:0];
            end else if (paddr == ADDR_Q) begin
                r_q <= pwdata[15:0];
            end
        end
    end

    always_comb begin
        p_m1     = (r_p >= 16'd1) ? r_p - 16'd1 : 16'd0;
        q_m1     = (r_q >= 16'd1) ? r_q - 16'd1 : 16'd0;
        n_prod   = {16'd0, r_p} * {16'd0, r_q};
        phi_prod = {16'd0, p_m1} * {16'd0, q_m1};
    end

    always_ff @(posedge i_clk) begin
        r_n   <= MW'(n_prod);
        r_phi <= MW'(phi_prod);
    end

    // handshake
    assign i_in.ready = (r_state == S_IDLE);
    assign accept     = i_in.valid && i_in.ready;
    assign out_free   = !r_ovalid || o_out.ready;
    assign chr_ok     = (i_in.plain_char >= CHAR_A) && (i_in.plain_char <= CHAR_Z);
    assign last_bit   = (r_bits == CW'(1));
    // taken from the live primes so a request right after a write sees the new modulus
    assign n_small    = (MW'(n_prod) < MW'(2));
    assign idx        = r_char - CHAR_A;
    assign k_val      = PUB_EXP - EW'(r_acc);

    // shared serial units
    always_comb begin
        mm_a = r_acc;
        mm_b = r_acc;
        mm_m = r_mod;
        unique case (r_state)
            S_RED_PHI: begin
                mm_a = MW'(1);
                mm_b = r_phi;
                mm_m = MW'(PUB_EXP);
            end
            S_RED_BASE: begin
                mm_a = MW'(1);
                mm_b = (r_cmd == CMD_DEC) ? MW'(r_cv) : MW'(idx);
                mm_m = r_n;
            end
            S_MUL: begin
                mm_a = r_base;
            end
            default: begin
            end
        endcase
    end

    assign mm_start = ((r_state == S_RED_PHI) || (r_state == S_RED_BASE) ||
                       (r_state == S_SQ) || (r_state == S_MUL)) && !r_issued;
    assign dv_start = (r_state == S_DIV) && !r_issued;

    rlm_modmul u_modmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mm_start),
        .i_a     (mm_a),
        .i_b     (mm_b),
        .i_m     (mm_m),
        .o_done  (mm_done),
        .o_res   (mm_res)
    );

    rlm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (dv_start),
        .i_num   (r_num),
        .o_done  (dv_done),
        .o_quo   (dv_quo)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_in.command == CMD_DEC) begin
                        n_state = S_RED_PHI;
                    end else if (!chr_ok || n_small) begin
                        n_state = S_FIN;
                    end else begin
                        n_state = S_RED_BASE;
                    end
                end
            end
            S_RED_PHI: if (mm_done) n_state = S_CHECK;
            S_CHECK: begin
                if ((r_phi < MW'(2)) || (r_base == '0)) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_SQ;
                end
            end
            S_SQ: begin
                if (mm_done) begin
                    if (r_exp[MW-1]) begin
                        n_state = S_MUL;
                    end else if (last_bit) begin
                        n_state = r_inv_phase ? S_PROD : S_FIN;
                    end
                end
            end
            S_MUL: begin
                if (mm_done) begin
                    if (last_bit) begin
                        n_state = r_inv_phase ? S_PROD : S_FIN;
                    end else begin
                        n_state = S_SQ;
                    end
                end
            end
            S_PROD: n_state = S_DIV;
            S_DIV: begin
                if (dv_done) begin
                    n_state = n_small ? S_FIN : S_RED_BASE;
                end
            end
            S_RED_BASE: if (mm_done) n_state = S_SQ;
            S_FIN: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_issued <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (mm_start || dv_start) begin
                r_issued <= 1'b1;
            end else if (mm_done || dv_done) begin
                r_issued <= 1'b0;
            end
            if (r_state == S_FIN && out_free) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    r_cmd    <= i_in.command;
                    r_char   <= i_in.plain_char;
                    r_cv     <= i_in.cipher_value;
                    r_acc    <= '0;
                    r_status <= ST_OK;
                    if (i_in.command == CMD_ENC && !chr_ok) begin
                        r_status <= ST_BAD_CHR;
                    end
                end
            end
            S_RED_PHI: if (mm_done) r_base <= mm_res;
            S_CHECK: begin
                r_acc       <= MW'(1);
                r_mod       <= MW'(PUB_EXP);
                r_exp       <= MW'(INV_EXP) << (MW - INV_BITS);
                r_bits      <= CW'(INV_BITS);
                r_inv_phase <= 1'b1;
                if ((r_phi < MW'(2)) || (r_base == '0)) begin
                    r_status <= ST_NO_INV;
                end
            end
            S_SQ, S_MUL: begin
                if (mm_done) begin
                    r_acc <= mm_res;
                    // a square followed by a multiply steps the exponent after the multiply
                    if (r_state == S_MUL || !r_exp[MW-1]) begin
                        r_exp  <= {r_exp[MW-2:0], 1'b0};
                        r_bits <= r_bits - 1'b1;
                    end
                end
            end
            S_PROD: r_num <= NW'(k_val) * NW'(r_phi) + NW'(1);
            S_DIV: begin
                if (dv_done) begin
                    r_d   <= dv_quo;
                    r_acc <= '0;
                end
            end
            S_RED_BASE: begin
                if (mm_done) begin
                    r_base      <= mm_res;
                    r_acc       <= MW'(1);
                    r_mod       <= r_n;
                    r_inv_phase <= 1'b0;
                    if (r_cmd == CMD_DEC) begin
                        r_exp  <= r_d;
                        r_bits <= CW'(MW);
                    end else begin
                        r_exp  <= MW'(PUB_EXP) << (MW - EW);
                        r_bits <= CW'(EW);
                    end
                end
            end
            S_FIN: begin
                if (out_free) begin
                    r_oval  <= (r_status == ST_OK) ? 32'(r_acc) : 32'd0;
                    r_ochar <= (r_status == ST_OK && r_cmd == CMD_DEC) ?
                               r_acc[7:0] + CHAR_A : 8'd0;
                    r_ostat <= r_status;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out.valid        = r_ovalid;
    assign o_out.result_value = r_oval;
    assign o_out.result_char  = r_ochar;
    assign o_out.status       = r_ostat;
endmodule

// File: rtl/core/rlm_modmul.sv
// rlm_modmul: bit-serial interleaved modular multiplier, a*b mod m, one bit of b a cycle
// depends on rlm_pkg; requires a < m
module rlm_modmul
    import rlm_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [MW-1:0] i_a,
    input  logic [MW-1:0] i_b,
    input  logic [MW-1:0] i_m,
    output logic          o_done,
    output logic [MW-1:0] o_res
);
    localparam int CW = $clog2(MW + 1);

    logic [MW-1:0] r_acc, r_b, r_a, r_m;
    logic [CW-1:0] r_cnt;
    logic          r_busy, r_done;
    logic [MW+1:0] t, t1, t2, m1, m2;
    logic [MW-1:0] n_acc;

    always_comb begin
        m1 = {2'b00, r_m};
        m2 = {1'b0, r_m, 1'b0};
        t  = {1'b0, r_acc, 1'b0} + (r_b[MW-1] ? {2'b00, r_a} : '0);
        t1 = t - m1;
        t2 = t - m2;
        if (t >= m2) begin
            n_acc = t2[MW-1:0];
        end else if (t >= m1) begin
            n_acc = t1[MW-1:0];
        end else begin
            n_acc = t[MW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(MW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_acc <= '0;
            r_a   <= i_a;
            r_b   <= i_b;
            r_m   <= i_m;
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_b   <= {r_b[MW-2:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_res  = r_acc;
endmodule

// File: rtl/core/rlm_div.sv
// rlm_div: bit-serial restoring divider by the public exponent, one quotient bit a cycle
// depends on rlm_pkg
module rlm_div
    import rlm_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    output logic          o_done,
    output logic [MW-1:0] o_quo
);
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] r_num, r_quo;
    logic [EW-1:0] r_rem;
    logic [CW-1:0] r_cnt;
    logic          r_busy, r_done;
    logic [EW:0]   t;
    logic          q_bit;

    always_comb begin
        t     = {r_rem, r_num[NW-1]};
        q_bit = (t >= {1'b0, PUB_EXP});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_num <= i_num;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[NW-2:0], 1'b0};
            r_rem <= q_bit ? EW'(t - {1'b0, PUB_EXP}) : t[EW-1:0];
            r_quo <= {r_quo[NW-2:0], q_bit};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo[MW-1:0];
endmodule

// File: rtl/core/rlm_checker.sv
// rlm_checker: port-level checks of the cipher result channel, bound to the top level
// depends on rlm_pkg for status codes
module rlm_checker
    import rlm_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_value,
    input logic [7:0]  i_out_char,
    input logic [1:0]  i_out_status
);
    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_value))
        else $error("result dropped or changed while stalled");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_status == ST_OK || i_out_status == ST_NO_INV ||
                         i_out_status == ST_BAD_CHR))
        else $error("undefined status code");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_status != ST_OK |-> i_out_value == 32'd0 && i_out_char == 8'd0)
        else $error("error result carries data");

    // one item at a time: no new request right after one was taken
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("request taken while busy");
endmodule

bind rsa_letter_modexp_cipher rlm_checker u_rlm_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_value  (o_out.result_value),
    .i_out_char   (o_out.result_char),
    .i_out_status (o_out.status)
);

// File: tb/rlm_checker.sv
// rlm_tb_checker: watches the request and result channels of the rsa letter cipher,
// predicts each result from the current primes and compares; depends on rlm_pkg, rlm_if
`timescale 1ns / 100ps

module rlm_tb_checker
    import rlm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    rlm_in_if.sink      in_mon,
    rlm_out_if.sink     out_mon,
    output int          o_errors,
    output int          o_pending,
    output int          o_results
);

    typedef struct packed {
        logic [31:0] value;
        logic [7:0]  chr;
        logic [1:0]  status;
    } t_cipher_res;

    t_cipher_res cipher_q[$];
    logic [15:0] cur_p, cur_q;

    function automatic logic [63:0] pow_mod(logic [63:0] base, logic [63:0] ex,
                                            logic [63:0] n);
        logic [63:0] acc;
        acc = 1;
        if (n < 2) return 0;
        base = base % n;
        while (ex != 0) begin
            if (ex[0]) acc = (acc * base) % n;
            base = (base * base) % n;
            ex = ex >> 1;
        end
        return acc;
    endfunction

    // extended euclid for 65537^-1 mod m; returns 0 when none exists
    function automatic bit priv_exp(logic [63:0] m, output logic [63:0] d);
        longint t0, t1, tn;
        logic [63:0] r0, r1, rn, qt;
        t0 = 0; t1 = 1; d = 0;
        if (m < 2) return 0;
        r0 = m;
        r1 = 64'd65537 % m;
        while (r1 != 0) begin
            qt = r0 / r1;
            rn = r0 - qt * r1;
            tn = t0 - longint'(qt) * t1;
            r0 = r1; r1 = rn; t0 = t1; t1 = tn;
        end
        if (r0 != 1) return 0;
        if (t0 < 0) d = m - (64'(-t0) % m);
        else d = 64'(t0) % m;
        if (d == m) d = 0;
        return 1;
    endfunction

    function automatic t_cipher_res predict_cipher(logic cmd, logic [7:0] ch,
                                                   logic [31:0] cv);
        t_cipher_res r;
        logic [63:0] n, a, b, phi, d;
        r = '0;
        n = (64'(cur_p) * 64'(cur_q)) & 64'hFFFF_FFFF;
        a = (cur_p >= 1) ? cur_p - 1 : 0;
        b = (cur_q >= 1) ? cur_q - 1 : 0;
        phi = (a * b) & 64'hFFFF_FFFF;
        if (cmd == CMD_ENC) begin
            if (ch < CHAR_A || ch > CHAR_Z) r.status = ST_BAD_CHR;
            else r.value = 32'(pow_mod(ch - CHAR_A, 65537, n));
        end else begin
            if (!priv_exp(phi, d)) r.status = ST_NO_INV;
            else begin
                r.value = 32'(pow_mod(cv, d, n));
                r.chr = r.value[7:0] + CHAR_A;
            end
        end
        return r;
    endfunction

    assign o_pending = cipher_q.size();

    always @(posedge i_clk) begin
        t_cipher_res exp_r;
        int          n_err;
        n_err = 0;
        if (!i_rst_n) begin
            cur_p <= RST_P;
            cur_q <= RST_Q;
            o_errors <= 0;
            o_results <= 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr == ADDR_P) cur_p <= pwdata[15:0];
                else if (paddr == ADDR_Q) cur_q <= pwdata[15:0];
            end
            if (in_mon.valid && in_mon.ready)
                cipher_q.push_back(predict_cipher(in_mon.command, in_mon.plain_char,
                                                  in_mon.cipher_value));
            if (out_mon.valid && out_mon.ready) begin
                o_results <= o_results + 1;
                if (cipher_q.size() == 0) begin
                    $error("result with no request outstanding");
                    n_err++;
                end else begin
                    exp_r = cipher_q.pop_front();
                    if (exp_r.value !== out_mon.result_value) begin
                        $error("result_value expected %0d got %0d", exp_r.value,
                               out_mon.result_value);
                        n_err++;
                    end
                    if (exp_r.chr !== out_mon.result_char) begin
                        $error("result_char expected %0d got %0d", exp_r.chr,
                               out_mon.result_char);
                        n_err++;
                    end
                    if (exp_r.status !== out_mon.status) begin
                        $error("status expected %0d got %0d", exp_r.status,
                               out_mon.status);
                        n_err++;
                    end
                end
            end
            if (n_err != 0) o_errors <= o_errors + n_err;
        end
    end

endmodule

// File: tb/tb_rsa_letter_modexp_cipher.sv
// tb_rsa_letter_modexp_cipher: drives the cipher with directed and random requests
// under several prime settings; depends on rlm_pkg, rlm_if, rlm_tb_checker and the block
`timescale 1ns / 100ps

module tb_rsa_letter_modexp_cipher;
    import rlm_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    int          errors, pending, results;
    int          sent = 0;
    int          idle_cycles = 0;
    bit          hold_rx = 1'b0;
    bit          done = 1'b0;

    rlm_in_if  in_ch();
    rlm_out_if out_ch();

    rsa_letter_modexp_cipher i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .pready(pready), .i_in(in_ch.sink), .o_out(out_ch.source)
    );

    rlm_tb_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .psel(psel), .penable(penable),
        .pwrite(pwrite), .pready(pready), .paddr(paddr), .pwdata(pwdata),
        .in_mon(in_ch.sink), .out_mon(out_ch.sink),
        .o_errors(errors), .o_pending(pending), .o_results(results)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        in_ch.valid = 1'b0;
        in_ch.command = 1'b0;
        in_ch.plain_char = '0;
        in_ch.cipher_value = '0;
        out_ch.ready = 1'b0;
    end

    // never zero, so valid drops before the next request goes up
    function automatic int gap_len();
        if ($urandom_range(0, 9) < 3) return 1;
        if ($urandom_range(0, 19) == 0) return $urandom_range(20, 200);
        return $urandom_range(1, 4);
    endfunction

    // receiver side: random stalls, plus a long hold when asked
    always @(posedge i_clk) begin
        if (!i_rst_n) out_ch.ready <= 1'b0;
        else if (hold_rx) out_ch.ready <= 1'b0;
        else out_ch.ready <= ($urandom_range(0, 3) != 0);
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 40000) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic send_request(logic cmd, logic [7:0] ch, logic [31:0] cv);
        int g;
        g = gap_len();
        repeat (g) @(posedge i_clk);
        in_ch.valid <= 1'b1;
        in_ch.command <= cmd;
        in_ch.plain_char <= ch;
        in_ch.cipher_value <= cv;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sent++;
        in_ch.valid <= 1'b0;
    endtask

    task automatic drain();
        while (pending != 0) @(posedge i_clk);
        repeat (5000) @(posedge i_clk);
    endtask

    task automatic random_phase(int count);
        int k;
        logic [7:0] ch;
        for (k = 0; k < count; k++) begin
            if ($urandom_range(0, 3) == 0) ch = 8'($urandom);
            else ch = 8'($urandom_range(65, 90));
            if ($urandom_range(0, 1) == 0) send_request(CMD_ENC, ch, $urandom);
            else if ($urandom_range(0, 2) == 0) send_request(CMD_DEC, ch, $urandom);
            else send_request(CMD_DEC, ch, $urandom_range(0, 70000));
        end
    endtask

    initial begin
        int k;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // directed, reset primes: letter extremes, bad chars, decrypt extremes
        send_request(CMD_ENC, 8'd65, 32'hFFFF_FFFF);
        send_request(CMD_ENC, 8'd90, 32'h0);
        send_request(CMD_ENC, 8'd64, 32'h0);
        send_request(CMD_ENC, 8'd91, 32'h0);
        send_request(CMD_ENC, 8'd0, 32'h0);
        send_request(CMD_ENC, 8'd255, 32'h0);
        send_request(CMD_DEC, 8'hFF, 32'd0);
        send_request(CMD_DEC, 8'h00, 32'd1);
        send_request(CMD_DEC, 8'h00, 32'd67590);
        send_request(CMD_DEC, 8'h00, 32'd67591);
        send_request(CMD_DEC, 8'h00, 32'hFFFF_FFFF);
        // long receiver hold while the sender keeps offering
        hold_rx = 1'b1;
        fork
            begin repeat (3000) @(posedge i_clk); hold_rx = 1'b0; end
            for (k = 0; k < 4; k++) send_request(CMD_ENC, 8'(65 + k), 0);
        join
        drain();
        random_phase(45);
        drain();
        // largest primes, extreme 16-bit values
        apb_write(ADDR_P, 32'hFFFF_FFF1);
        apb_write(ADDR_Q, 32'h0000_FFF1);
        send_request(CMD_ENC, 8'd90, 0);
        send_request(CMD_DEC, 8'd0, 32'hFFFF_FFFF);
        random_phase(30);
        drain();
        // small factors: phi zero, degenerate modulus
        apb_write(ADDR_P, 32'd0);
        apb_write(ADDR_Q, 32'd1);
        send_request(CMD_ENC, 8'd66, 0);
        send_request(CMD_DEC, 8'd0, 32'd5);
        drain();
        apb_write(ADDR_P, 32'd2);
        apb_write(ADDR_Q, 32'd2);
        send_request(CMD_ENC, 8'd67, 0);
        send_request(CMD_DEC, 8'd0, 32'd3);
        drain();
        // smallest and largest 16-bit factors together
        apb_write(ADDR_P, 32'd2);
        apb_write(ADDR_Q, 32'd65535);
        random_phase(10);
        drain();
        apb_write(ADDR_P, 32'd61);
        apb_write(ADDR_Q, 32'd53);
        random_phase(40);
        drain();
        $display("covered %0d requests and %0d results over six prime settings",
                 sent, results);
        if (errors == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end

endmodule
